// ===== src/ubd_pkg.sv =====
// ---------------------------------------------------------------------------
// ubd_pkg: shared constants for the baud divisor calculator
// Widths, scale factors and reciprocal constants used by the datapath.
// ---------------------------------------------------------------------------
package ubd_pkg;

  localparam int CLK_W        = 32;
  localparam int BAUD_BITS_DEF = 22;
  localparam logic [CLK_W-1:0] CLOCK_RESET = 32'd3000000000;

  // register map
  localparam logic [0:0] REG_CLOCK = 1'b0;

  // integer part of (2^32-1)/1000 fits in 23 bits
  localparam int IPART_W = 23;
  localparam int FPART_W = 7;
  localparam int REM_W   = 10;
  localparam int DEN_W   = 33;

  localparam int SCALE      = 1000;
  localparam int HALF_SCALE = 500;
  localparam int FRAC_SHIFT = 6;
  localparam int INT_LIMIT  = 16'hFFFF;
  localparam int FRAC_LIMIT = 6'h3F;
  localparam logic [7:0] ERR_SAT = 8'd255;

  // x/1000 = (x*M1)>>41 exact for 32-bit x
  localparam logic [31:0] M1 = 32'd2199023256;
  localparam int M1_SHIFT = 41;
  // t/1000 = (t*M2)>>26 exact for t below 65536
  localparam logic [16:0] M2 = 17'd67109;
  localparam int M2_SHIFT = 26;

endpackage

// ===== src/ubd_div_cell.sv =====
// ---------------------------------------------------------------------------
// ubd_div_cell: one restoring division step
// Shifts one numerator bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit into the numerator register.
// ---------------------------------------------------------------------------
module ubd_div_cell #(
  parameter int NW = 32,
  parameter int DW = 26,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [NW-1:0] in_nq,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] out_rem,
  output logic [NW-1:0] out_nq,
  output logic [DW-1:0] out_div,
  output logic [SW-1:0] out_side
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        qbit;

  // trial subtract
  always_comb begin
    trial = {in_rem, in_nq[NW-1]};
    diff  = trial - {1'b0, in_div};
    qbit  = (trial >= {1'b0, in_div});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= qbit ? diff[DW-1:0] : trial[DW-1:0];
      out_nq   <= {in_nq[NW-2:0], qbit};
      out_div  <= in_div;
      out_side <= in_side;
    end
  end

endmodule

// ===== src/ubd_div_chain.sv =====
// ---------------------------------------------------------------------------
// ubd_div_chain: pipelined restoring divider
// A row of NW division cells; one quotient bit per cell, one transaction
// may enter every cycle while en is high.
// ---------------------------------------------------------------------------
module ubd_div_chain #(
  parameter int NW = 32,
  parameter int DW = 26,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          v    [0:NW];
  logic [DW-1:0] rem  [0:NW];
  logic [NW-1:0] nq   [0:NW];
  logic [DW-1:0] dv   [0:NW];
  logic [SW-1:0] side [0:NW];

  assign v[0]    = in_valid;
  assign rem[0]  = in_rem;
  assign nq[0]   = in_num;
  assign dv[0]   = in_div;
  assign side[0] = in_side;

  // one cell per quotient bit
  for (genvar i = 0; i < NW; i++) begin : g_cell
    ubd_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v[i]),
      .in_rem   (rem[i]),
      .in_nq    (nq[i]),
      .in_div   (dv[i]),
      .in_side  (side[i]),
      .out_valid(v[i+1]),
      .out_rem  (rem[i+1]),
      .out_nq   (nq[i+1]),
      .out_div  (dv[i+1]),
      .out_side (side[i+1])
    );
  end

  assign out_valid = v[NW];
  assign out_quo   = nq[NW];
  assign out_side  = side[NW];

endmodule

// ===== src/uart_baud_divisor_calc_core.sv =====
// ---------------------------------------------------------------------------
// uart_baud_divisor_calc_core: fractional UART baud divisor calculator
// Turns a requested baud rate into integer and 64ths divisors, the rate
// error in percent and range flags.
// ---------------------------------------------------------------------------
// Usage:
//  - Write clock_scaled over the APB port (byte address 0) while idle.
//  - Each request on baud_rate (valid/ready) yields exactly one result on
//    the output channel, in order.
//  - A result passes through 32 cells for clock/(16*baud), four stages of
//    reciprocal scaling, 32 cells for the regenerated rate, two stages of
//    error product, 8 cells for the error quotient and one output register.
//  - Throughput is one transaction per cycle while the output is not stalled;
//    the cell chains set it, each cell producing one quotient bit.
//  - When the receiver stalls, the whole pipeline holds and in_ready drops;
//    a new request is taken in the same cycle the held result is taken.
//  - Reset empties the pipeline and loads clock_scaled with 3000000000.
//  - Zero baud or zero regenerated divisor: bad_rate set, other fields 0.
// ---------------------------------------------------------------------------
module uart_baud_divisor_calc_core
  import ubd_pkg::*;
#(
  parameter int BAUD_BITS = BAUD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // APB configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BAUD_BITS-1:0] baud_rate,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [27:0]          int_divisor,
  output logic [6:0]           frac_divisor,
  output logic [7:0]           error_percent,
  output logic                 out_of_range,
  output logic                 bad_rate
);

  localparam int D1W  = BAUD_BITS + 4;
  localparam int D2W  = DEN_W + 4;
  localparam int S2W  = BAUD_BITS + IPART_W + FPART_W + 1;
  localparam int S3W  = IPART_W + FPART_W + 2;

  logic [CLK_W-1:0] clock_scaled;
  logic             adv;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_scaled <= CLOCK_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 &&
                 paddr[2] == REG_CLOCK) begin
      clock_scaled <= pwdata;
    end
  end
  assign prdata = (paddr[2] == REG_CLOCK) ? clock_scaled : 32'd0;

  // pipeline advances whenever the output register is free or drained
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: bdiv = clock / (16*baud)
  logic                 c1_valid;
  logic [CLK_W-1:0]     c1_quo;
  logic [BAUD_BITS-1:0] c1_baud;

  ubd_div_chain #(.NW(CLK_W), .DW(D1W), .SW(BAUD_BITS)) u_div_bdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (in_valid),
    .in_rem   ({D1W{1'b0}}),
    .in_num   (clock_scaled),
    .in_div   ({baud_rate, 4'b0000}),
    .in_side  (baud_rate),
    .out_valid(c1_valid),
    .out_quo  (c1_quo),
    .out_side (c1_baud)
  );

  // stage A: reciprocal product for bdiv/1000
  logic                 a_valid;
  logic [CLK_W-1:0]     a_bdiv;
  logic [63:0]          a_prod;
  logic [BAUD_BITS-1:0] a_baud;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= c1_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_bdiv <= c1_quo;
      a_prod <= c1_quo * M1;
      a_baud <= c1_baud;
    end
  end

  // stage B: integer part and remainder
  logic                 b_valid;
  logic [IPART_W-1:0]   b_ipart;
  logic [REM_W-1:0]     b_rem;
  logic [BAUD_BITS-1:0] b_baud;
  logic [IPART_W-1:0]   ipart_calc;
  logic [CLK_W-1:0]     rem_calc;

  always_comb begin
    ipart_calc = a_prod[M1_SHIFT +: IPART_W];
    rem_calc   = a_bdiv - CLK_W'(ipart_calc * SCALE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_ipart <= ipart_calc;
      b_rem   <= rem_calc[REM_W-1:0];
      b_baud  <= a_baud;
    end
  end

  // stage C: rounded fraction in 64ths
  logic                 cc_valid;
  logic [IPART_W-1:0]   cc_ipart;
  logic [FPART_W-1:0]   cc_fpart;
  logic [BAUD_BITS-1:0] cc_baud;
  logic [15:0]          frac_num;
  logic [32:0]          frac_prod;

  always_comb begin
    frac_num  = {b_rem, 6'b000000} + 16'(HALF_SCALE);
    frac_prod = frac_num * M2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cc_valid <= 1'b0;
    end else if (adv) begin
      cc_valid <= b_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cc_ipart <= b_ipart;
      cc_fpart <= frac_prod[M2_SHIFT +: FPART_W];
      cc_baud  <= b_baud;
    end
  end

  // stage D: regenerated denominator
  logic                 d_valid;
  logic [DEN_W-1:0]     d_den;
  logic [IPART_W-1:0]   d_ipart;
  logic [FPART_W-1:0]   d_fpart;
  logic [BAUD_BITS-1:0] d_baud;
  logic                 d_bad;
  logic [DEN_W-1:0]     den_calc;
  logic [16:0]          frac_scaled;

  always_comb begin
    frac_scaled = 17'(cc_fpart * SCALE);
    den_calc    = DEN_W'(cc_ipart * SCALE) +
                  DEN_W'(frac_scaled >> FRAC_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= cc_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      d_den   <= den_calc;
      d_ipart <= cc_ipart;
      d_fpart <= cc_fpart;
      d_baud  <= cc_baud;
      d_bad   <= (cc_baud == '0) || (den_calc == '0);
    end
  end

  // stage 2: gen = clock / (16*den)
  logic                 c2_valid;
  logic [CLK_W-1:0]     c2_gen;
  logic [S2W-1:0]       c2_side;

  ubd_div_chain #(.NW(CLK_W), .DW(D2W), .SW(S2W)) u_div_gen (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (d_valid),
    .in_rem   ({D2W{1'b0}}),
    .in_num   (clock_scaled),
    .in_div   ({d_den, 4'b0000}),
    .in_side  ({d_baud, d_ipart, d_fpart, d_bad}),
    .out_valid(c2_valid),
    .out_quo  (c2_gen),
    .out_side (c2_side)
  );

  logic [BAUD_BITS-1:0] c2_baud;
  logic [IPART_W-1:0]   c2_ipart;
  logic [FPART_W-1:0]   c2_fpart;
  logic                 c2_bad;
  assign {c2_baud, c2_ipart, c2_fpart, c2_bad} = c2_side;

  // stage E: |gen - baud| * 100
  logic                 e_valid;
  logic [38:0]          e_prod;
  logic [BAUD_BITS-1:0] e_baud;
  logic [IPART_W-1:0]   e_ipart;
  logic [FPART_W-1:0]   e_fpart;
  logic                 e_bad;
  logic [CLK_W-1:0]     gen_diff;
  logic [CLK_W-1:0]     baud_ext;

  always_comb begin
    baud_ext = CLK_W'(c2_baud);
    gen_diff = (c2_gen >= baud_ext) ? (c2_gen - baud_ext) : (baud_ext - c2_gen);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= c2_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      e_prod  <= gen_diff * 7'd100;
      e_baud  <= c2_baud;
      e_ipart <= c2_ipart;
      e_fpart <= c2_fpart;
      e_bad   <= c2_bad;
    end
  end

  // stage F: saturation check, seed of the error division
  logic                 f_valid;
  logic [BAUD_BITS-1:0] f_rem;
  logic [7:0]           f_low;
  logic [BAUD_BITS-1:0] f_baud;
  logic [IPART_W-1:0]   f_ipart;
  logic [FPART_W-1:0]   f_fpart;
  logic                 f_bad;
  logic                 f_sat;
  logic                 sat_calc;

  assign sat_calc = (e_prod[38:8] >= 31'(e_baud));

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      f_rem   <= sat_calc ? '0 : e_prod[8 +: BAUD_BITS];
      f_low   <= e_prod[7:0];
      f_baud  <= e_baud;
      f_ipart <= e_ipart;
      f_fpart <= e_fpart;
      f_bad   <= e_bad;
      f_sat   <= sat_calc;
    end
  end

  // stage 3: error quotient, 8 bits
  logic                 c3_valid;
  logic [7:0]           c3_quo;
  logic [S3W-1:0]       c3_side;

  ubd_div_chain #(.NW(8), .DW(BAUD_BITS), .SW(S3W)) u_div_err (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (f_valid),
    .in_rem   (f_rem),
    .in_num   (f_low),
    .in_div   (f_baud),
    .in_side  ({f_ipart, f_fpart, f_bad, f_sat}),
    .out_valid(c3_valid),
    .out_quo  (c3_quo),
    .out_side (c3_side)
  );

  logic [IPART_W-1:0] c3_ipart;
  logic [FPART_W-1:0] c3_fpart;
  logic               c3_bad;
  logic               c3_sat;
  assign {c3_ipart, c3_fpart, c3_bad, c3_sat} = c3_side;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c3_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      bad_rate      <= c3_bad;
      int_divisor   <= c3_bad ? 28'd0 : 28'(c3_ipart);
      frac_divisor  <= c3_bad ? 7'd0 : c3_fpart;
      error_percent <= c3_bad ? 8'd0 : (c3_sat ? ERR_SAT : c3_quo);
      out_of_range  <= !c3_bad && ((32'(c3_ipart) > 32'(INT_LIMIT)) ||
                                   (32'(c3_fpart) > 32'(FRAC_LIMIT)));
    end
  end

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_rate |-> int_divisor == 28'd0 && frac_divisor == 7'd0 &&
                              error_percent == 8'd0 && !out_of_range)
    else $error("bad_rate result carries nonzero fields");

  a_frac_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frac_divisor <= 7'd64)
    else $error("fraction above 64");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(error_percent))
    else $error("stalled result changed");
`endif

endmodule
